// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the plane segment intersect top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/psic_pkg.sv =====
// Package for the plane segment intersect and classify block
`default_nettype none
package psic_pkg;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int NORMAL_W        = 18;
    localparam int SPLIT_BITS      = 24;
    localparam int OUT_W           = 32;
    localparam int TOL_W           = 16;
    localparam int T_W             = 17;
    localparam int DIV_N           = 48;
    localparam int DIV_D           = 33;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 32;

    localparam logic [CFG_IDX_W-1:0] REG_NX  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NY  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NZ  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_D   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TOL = 3'd4;

    localparam logic [1:0] SIDE_FRONT = 2'd0;
    localparam logic [1:0] SIDE_BACK  = 2'd1;
    localparam logic [1:0] SIDE_ON    = 2'd2;

    typedef struct packed {
        logic signed [NORMAL_W-1:0] nx;
        logic signed [NORMAL_W-1:0] ny;
        logic signed [NORMAL_W-1:0] nz;
        logic signed [OUT_W-1:0]    d;
        logic [TOL_W-1:0]           tol;
    } plane_t;

    function automatic logic signed [OUT_W-1:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return x[OUT_W-1:0];
    endfunction
endpackage
`default_nettype wire

// ===== rtl/core/psic_dist.sv =====
// Pipelined signed plane distance of one point, three register stages
`default_nettype none
module psic_dist #(
    parameter int COORD_WIDTH = psic_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = psic_pkg::FRAC_BITS_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              en,
    input  wire psic_pkg::plane_t                  plane,
    input  wire logic signed [COORD_WIDTH-1:0]     px,
    input  wire logic signed [COORD_WIDTH-1:0]     py,
    input  wire logic signed [COORD_WIDTH-1:0]     pz,
    output logic signed [psic_pkg::OUT_W-1:0]      dout
);
    localparam int SB = psic_pkg::SPLIT_BITS;
    localparam int HW = (COORD_WIDTH > SB) ? COORD_WIDTH - SB : 1;
    localparam int PW = 64;

    logic signed [PW-1:0] ph_reg [3];
    logic signed [PW-1:0] pl_reg [3];
    logic signed [PW-1:0] hs_reg, ls_reg;
    logic signed [PW-1:0] ph_next [3];
    logic signed [PW-1:0] pl_next [3];
    logic signed [COORD_WIDTH-1:0] pc [3];
    logic signed [psic_pkg::NORMAL_W-1:0] nn [3];

    always_comb begin
        pc[0] = px; pc[1] = py; pc[2] = pz;
        nn[0] = plane.nx; nn[1] = plane.ny; nn[2] = plane.nz;
        for (int i = 0; i < 3; i++) begin
            logic signed [PW-1:0] cw, ch, cl;
            cw = PW'(pc[i]);
            ch = cw >>> SB;
            cl = cw - (ch <<< SB);
            ph_next[i] = PW'(nn[i]) * ch;
            pl_next[i] = PW'(nn[i]) * cl;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                ph_reg[i] <= ph_next[i];
                pl_reg[i] <= pl_next[i];
            end
            hs_reg <= ph_reg[0] + ph_reg[1] + ph_reg[2];
            ls_reg <= pl_reg[0] + pl_reg[1] + pl_reg[2];
            dout <= psic_pkg::sat32((hs_reg <<< (SB - FRAC_BITS)) + (ls_reg >>> FRAC_BITS)
                                    + PW'(plane.d));
        end
    end
    logic unused_hw;
    assign unused_hw = (HW > 0);
endmodule
`default_nettype wire

// ===== rtl/core/psic_div.sv =====
// Pipelined restoring divider, one quotient bit per stage
`default_nettype none
module psic_div (
    input  wire logic                          aclk,
    input  wire logic                          en,
    input  wire logic [psic_pkg::DIV_N-1:0]    num,
    input  wire logic [psic_pkg::DIV_D-1:0]    den,
    output logic [psic_pkg::T_W-1:0]           quo
);
    localparam int N = psic_pkg::DIV_N;
    localparam int D = psic_pkg::DIV_D;
    localparam int QB = psic_pkg::T_W;

    // quotient fits 17 bits since num <= den << 16
    logic [D:0]   rem_reg [QB+1];
    logic [N-1:0] num_reg [QB+1];
    logic [D-1:0] den_reg [QB+1];
    logic [QB-1:0] q_reg  [QB+1];

    always_comb begin
        rem_reg[0] = '0;
        num_reg[0] = num;
        den_reg[0] = den;
        q_reg[0]   = '0;
    end

    for (genvar s = 0; s < QB; s++) begin : g_st
        logic [D:0] r_sh;
        logic [D:0] r_sub;
        logic       q_bit;
        logic [N-1:0] hi_part;
        always_comb begin
            hi_part = num_reg[s] >> (QB - 1 - s);
            if (s == 0) r_sh = (D+1)'(hi_part);
            else        r_sh = {rem_reg[s][D-1:0], num_reg[s][QB-1-s]};
            r_sub = r_sh - {1'b0, den_reg[s]};
            q_bit = (r_sh >= {1'b0, den_reg[s]});
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s+1] <= q_bit ? r_sub : r_sh;
                num_reg[s+1] <= num_reg[s];
                den_reg[s+1] <= den_reg[s];
                q_reg[s+1]   <= {q_reg[s][QB-2:0], q_bit};
            end
        end
    end
    assign quo = q_reg[QB];
endmodule
`default_nettype wire

// ===== rtl/core/plane_segment_intersect_classify.sv =====
// Top level: plane distance, side and segment crossing pipeline
//  channel | dir | tdata (low bit first)           | tuser
//  s_      | in  | a_x a_y a_z b_x b_y b_z        | cmd
//  m_      | out | distance side hit hit_x y z    | -
//  cfg     | in  | wr_en, wr_index, wr_data        | -
// One word per cycle while the output is not stalled; the pipe runs through distance, divider and lerp stages.
// The whole pipe advances when the output register is free or taken; a stall freezes all.
// aresetn is synchronous; it clears valid bits and loads register reset values.
`default_nettype none
`include "assert_macros.svh"
module plane_segment_intersect_classify #(
    parameter int COORD_WIDTH = psic_pkg::COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = psic_pkg::FRAC_BITS_DEF
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic [psic_pkg::CFG_IDX_W-1:0]     cfg_wr_index,
    input  wire logic [psic_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z
    input  wire logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    // cmd
    input  wire logic                               s_tuser,
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // distance, side, hit, hit_x, hit_y, hit_z
    output logic [135:0]                            m_tdata
);
    localparam int CW = COORD_WIDTH;
    localparam int LAT = 3 + psic_pkg::T_W + 2;
    localparam int TW = psic_pkg::T_W;

    psic_pkg::plane_t plane_reg;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plane_reg.nx  <= '0;
            plane_reg.ny  <= 18'sd65536;
            plane_reg.nz  <= '0;
            plane_reg.d   <= '0;
            plane_reg.tol <= 16'd16;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                psic_pkg::REG_NX:  plane_reg.nx  <= cfg_wr_data[psic_pkg::NORMAL_W-1:0];
                psic_pkg::REG_NY:  plane_reg.ny  <= cfg_wr_data[psic_pkg::NORMAL_W-1:0];
                psic_pkg::REG_NZ:  plane_reg.nz  <= cfg_wr_data[psic_pkg::NORMAL_W-1:0];
                psic_pkg::REG_D:   plane_reg.d   <= cfg_wr_data;
                psic_pkg::REG_TOL: plane_reg.tol <= cfg_wr_data[psic_pkg::TOL_W-1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic [LAT-1:0] vld_reg;
    assign en = !m_tvalid || m_tready;
    assign s_tready = en;

    logic signed [CW-1:0] ax, ay, az, bx, by, bz;
    assign ax = s_tdata[0*CW +: CW];
    assign ay = s_tdata[1*CW +: CW];
    assign az = s_tdata[2*CW +: CW];
    assign bx = s_tdata[3*CW +: CW];
    assign by = s_tdata[4*CW +: CW];
    assign bz = s_tdata[5*CW +: CW];

    always_ff @(posedge aclk) begin
        if (!aresetn) vld_reg <= '0;
        else if (en) vld_reg <= {vld_reg[LAT-2:0], s_tvalid};
    end
    assign m_tvalid = vld_reg[LAT-1];

    logic signed [31:0] da, db;
    psic_dist #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_da (
        .aclk(aclk), .en(en), .plane(plane_reg), .px(ax), .py(ay), .pz(az), .dout(da));
    psic_dist #(.COORD_WIDTH(CW), .FRAC_BITS(FRAC_BITS)) u_db (
        .aclk(aclk), .en(en), .plane(plane_reg), .px(bx), .py(by), .pz(bz), .dout(db));

    // carry A, B, cmd along the 3 distance stages
    logic signed [CW-1:0] a_d_reg [3][3];
    logic signed [CW-1:0] b_d_reg [3][3];
    logic                 c_d_reg [3];
    always_ff @(posedge aclk) begin
        if (en) begin
            a_d_reg[0] <= '{ax, ay, az};
            b_d_reg[0] <= '{bx, by, bz};
            c_d_reg[0] <= s_tuser;
            for (int k = 1; k < 3; k++) begin
                a_d_reg[k] <= a_d_reg[k-1];
                b_d_reg[k] <= b_d_reg[k-1];
                c_d_reg[k] <= c_d_reg[k-1];
            end
        end
    end

    logic [63:0] mda, mdiff, num_full;
    logic signed [32:0] dd;
    logic hit_now;
    always_comb begin
        dd = 33'(da) - 33'(db);
        mda = da[31] ? 64'(-65'(da)) : 64'(da);
        mdiff = dd[32] ? 64'(-dd) : 64'(dd);
        num_full = mda << 16;
        hit_now = c_d_reg[2] && (da != db)
               && ((!da[31] && (db[31] || db == 0)) || ((da[31] || da == 0) && !db[31]));
    end

    logic [TW-1:0] t_q;
    psic_div u_div (.aclk(aclk), .en(en),
        .num(num_full[psic_pkg::DIV_N-1:0]), .den(mdiff[psic_pkg::DIV_D-1:0]), .quo(t_q));

    logic signed [CW-1:0] a_q_reg [TW][3];
    logic signed [CW-1:0] b_q_reg [TW][3];
    logic signed [31:0]   da_q_reg [TW];
    logic                 hit_q_reg [TW];
    always_ff @(posedge aclk) begin
        if (en) begin
            a_q_reg[0] <= a_d_reg[2];
            b_q_reg[0] <= b_d_reg[2];
            da_q_reg[0] <= da;
            hit_q_reg[0] <= hit_now;
            for (int k = 1; k < TW; k++) begin
                a_q_reg[k] <= a_q_reg[k-1];
                b_q_reg[k] <= b_q_reg[k-1];
                da_q_reg[k] <= da_q_reg[k-1];
                hit_q_reg[k] <= hit_q_reg[k-1];
            end
        end
    end

    // lerp: stage 1 multiply, stage 2 add and saturate
    logic signed [63:0] mh_reg [3];
    logic signed [63:0] ml_reg [3];
    logic signed [CW-1:0] a_l_reg [3];
    logic signed [CW-1:0] b_l_reg [3];
    logic                 one_reg, hit_l_reg;
    logic signed [31:0]   da_l_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                logic signed [63:0] diff, dh, dl;
                diff = 64'(b_q_reg[TW-1][i]) - 64'(a_q_reg[TW-1][i]);
                dh = diff >>> 16;
                dl = diff - (dh <<< 16);
                mh_reg[i] <= dh * $signed({47'd0, t_q});
                ml_reg[i] <= dl * $signed({47'd0, t_q});
            end
            a_l_reg <= a_q_reg[TW-1];
            b_l_reg <= b_q_reg[TW-1];
            one_reg <= t_q[TW-1];
            hit_l_reg <= hit_q_reg[TW-1];
            da_l_reg <= da_q_reg[TW-1];
        end
    end

    logic signed [31:0] o_dist_reg, hp_reg [3];
    logic [1:0] o_side_reg;
    logic o_hit_reg;
    always_ff @(posedge aclk) begin
        if (en) begin
            o_dist_reg <= da_l_reg;
            if (da_l_reg > $signed({16'd0, plane_reg.tol})) o_side_reg <= psic_pkg::SIDE_FRONT;
            else if (da_l_reg < -$signed({16'd0, plane_reg.tol}))
                o_side_reg <= psic_pkg::SIDE_BACK;
            else o_side_reg <= psic_pkg::SIDE_ON;
            o_hit_reg <= hit_l_reg;
            for (int i = 0; i < 3; i++) begin
                if (!hit_l_reg) hp_reg[i] <= '0;
                else if (one_reg) hp_reg[i] <= psic_pkg::sat32(64'(b_l_reg[i]));
                else hp_reg[i] <= psic_pkg::sat32(64'(a_l_reg[i]) + mh_reg[i]
                                                  + (ml_reg[i] >>> 16));
            end
        end
    end

    assign m_tdata = {5'd0, hp_reg[2], hp_reg[1], hp_reg[0], o_hit_reg, o_side_reg,
                      o_dist_reg};

    `ASSERT_IMPL(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready, !s_tready)
    `ASSERT_NEXT(a_out_stable, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))
    `ASSERT_IMPL(a_side_code, aclk, aresetn, m_tvalid, o_side_reg != 2'd3)
endmodule
`default_nettype wire
